### src/stoq_pkg.sv
// Package for the sorted timeout queue: item types, entry type, codes and
// the wrap-safe time compare. No dependencies.
`timescale 1ns / 1ps

package stoq_pkg;

   localparam int QUEUE_DEPTH  = 16;
   localparam int MAX_RESULTS  = 16;
   localparam int RESULT_CNT_W = (MAX_RESULTS > 1) ? $clog2(MAX_RESULTS) : 1;

   localparam logic KIND_TICK   = 1'b0;
   localparam logic KIND_INSERT = 1'b1;

   localparam logic STATUS_EXPIRED  = 1'b0;
   localparam logic STATUS_REJECTED = 1'b1;

   typedef struct packed {
      logic        kind;
      logic [15:0] delay_ticks;
      logic [7:0]  requester;
      logic [15:0] request_tag;
   } req_type;

   typedef struct packed {
      logic        status;
      logic [7:0]  notify_id;
      logic [15:0] result_tag;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic        valid;
      logic [31:0] expiry;
      logic [7:0]  owner;
      logic [15:0] tag;
   } entry_type;

   // one command to every cell of the chain
   typedef struct packed {
      logic insert;
      logic pop;
   } cell_op_type;

   // a at or before b: signed difference a - b is zero or negative
   function automatic logic at_or_before(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] d;
      d = a - b;
      return (d == 32'd0) || d[31];
   endfunction

endpackage

### src/stoq_cell.sv
// One slot of the sorted chain: holds an entry, keeps it, takes the new
// entry, or takes a neighbor's entry. Depends on stoq_pkg.
`timescale 1ns / 1ps

module stoq_cell import stoq_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cell_op_type op,
   input  entry_type   new_entry,
   input  entry_type   left_entry,
   input  entry_type   right_entry,
   input  logic        left_keep,
   output entry_type   entry,
   output logic        keep
);

   entry_type entry_ff;
   entry_type entry_in;

   // entry stays in place on insert when it expires no later than the new one
   assign keep  = entry_ff.valid && at_or_before(entry_ff.expiry, new_entry.expiry);
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (op.insert) begin
         if (!keep) begin
            entry_in = left_keep ? new_entry : left_entry;
         end
      end else if (op.pop) begin
         entry_in = right_entry;
      end
   end

   // only the valid bit is cleared; payload is don't-care while invalid
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid  <= 1'b0;
         entry_ff.expiry <= entry_in.expiry;
         entry_ff.owner  <= entry_in.owner;
         entry_ff.tag    <= entry_in.tag;
      end else begin
         entry_ff <= entry_in;
      end
   end

endmodule

### src/stoq_chain.sv
// Row of QUEUE_DEPTH stoq_cell slots, sorted head first.
// Depends on stoq_pkg and stoq_cell.
`timescale 1ns / 1ps

module stoq_chain import stoq_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cell_op_type op,
   input  entry_type   new_entry,
   output entry_type   head,
   output entry_type   second,
   output logic        full
);

   entry_type cells [QUEUE_DEPTH];
   logic      keeps [QUEUE_DEPTH];

   genvar i;
   generate
      for (i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
         entry_type left_e;
         entry_type right_e;
         logic      left_k;

         if (i == 0) begin : g_first
            assign left_e = new_entry;
            assign left_k = 1'b1;
         end else begin : g_mid
            assign left_e = cells[i-1];
            assign left_k = keeps[i-1];
         end

         if (i == QUEUE_DEPTH - 1) begin : g_last
            assign right_e = '0;
         end else begin : g_inner
            assign right_e = cells[i+1];
         end

         stoq_cell u_cell (
            .clock       (clock),
            .reset       (reset),
            .op          (op),
            .new_entry   (new_entry),
            .left_entry  (left_e),
            .right_entry (right_e),
            .left_keep   (left_k),
            .entry       (cells[i]),
            .keep        (keeps[i])
         );
      end
   endgenerate

   assign head   = cells[0];
   assign second = cells[1];
   assign full   = cells[QUEUE_DEPTH-1].valid;

endmodule

### src/sorted_timeout_queue_unit.sv
// Top level of the sorted timeout queue: control, time counter, result register.
// Depends on stoq_pkg and stoq_chain.
`timescale 1ns / 1ps

// Sorted timeout queue. Up to QUEUE_DEPTH pending timeouts sit in a chain of
// cells sorted by absolute expiry (now + 1 + delay_ticks, 32-bit, wrapping;
// order by signed difference, equal expiries leave in arrival order).
// On an insert item every cell compares its expiry with the new one in
// parallel and the chain opens a gap in that same cycle; it gives no result
// unless the queue is full, in which case the item goes to the reject state
// and one rejected item (status 1, last 1) is then loaded into the result
// register. A tick item advances the time and then the chain shifts one
// expired head into the result register per cycle while that register is free,
// up to MAX_RESULTS, the final one flagged last. A tick passes through the
// drain state to check the head even when nothing expires, and the head
// shift waits on the result register while rsp_ready is held low. req_ready
// is high only while no tick or reject is in progress; an insert may be
// taken while a result still waits in the result register.

module sorted_timeout_queue_unit import stoq_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_DRAIN,
      S_REJECT
   } state_type;

   state_type                state_ff;
   logic [31:0]              time_ff;
   logic [RESULT_CNT_W-1:0]  count_ff;   // results emitted for this tick
   logic                     rsp_valid_ff;
   rsp_type                  rsp_ff;
   logic [7:0]               rej_owner_ff;
   logic [15:0]              rej_tag_ff;

   cell_op_type op;
   entry_type   new_entry;
   entry_type   head;
   entry_type   second;
   logic        full;
   logic        accept;
   logic        out_free;
   logic        head_exp;
   logic        second_exp;
   logic        is_last;
   logic        rsp_load;

   stoq_chain u_chain (
      .clock     (clock),
      .reset     (reset),
      .op        (op),
      .new_entry (new_entry),
      .head      (head),
      .second    (second),
      .full      (full)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign new_entry.valid  = 1'b1;
   assign new_entry.expiry = time_ff + 32'd1 + {16'd0, req_data.delay_ticks};
   assign new_entry.owner  = req_data.requester;
   assign new_entry.tag    = req_data.request_tag;

   // time_ff already holds the advanced time while draining
   assign head_exp   = head.valid && at_or_before(head.expiry, time_ff);
   assign second_exp = second.valid && at_or_before(second.expiry, time_ff);
   assign is_last    = !second_exp ||
                       (count_ff == RESULT_CNT_W'(MAX_RESULTS - 1));

   assign op.insert = accept && (req_data.kind == KIND_INSERT) && !full;
   assign op.pop    = (state_ff == S_DRAIN) && head_exp && out_free;

   // result register loads an expired head or a reject
   assign rsp_load  = op.pop || ((state_ff == S_REJECT) && out_free);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         time_ff      <= 32'd0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  if (req_data.kind == KIND_TICK) begin
                     time_ff  <= time_ff + 32'd1;
                     count_ff <= '0;
                     state_ff <= S_DRAIN;
                  end else if (full) begin
                     rej_owner_ff <= req_data.requester;
                     rej_tag_ff   <= req_data.request_tag;
                     state_ff     <= S_REJECT;
                  end
               end
            end
            S_DRAIN: begin
               if (!head_exp) begin
                  state_ff <= S_IDLE;
               end else if (out_free) begin
                  rsp_ff.status      <= STATUS_EXPIRED;
                  rsp_ff.notify_id   <= head.owner;
                  rsp_ff.result_tag  <= head.tag;
                  rsp_ff.last        <= is_last;
                  count_ff           <= count_ff + RESULT_CNT_W'(1);
                  if (is_last) begin
                     state_ff <= S_IDLE;
                  end
               end
            end
            S_REJECT: begin
               if (out_free) begin
                  rsp_ff.status      <= STATUS_REJECTED;
                  rsp_ff.notify_id   <= rej_owner_ff;
                  rsp_ff.result_tag  <= rej_tag_ff;
                  rsp_ff.last        <= 1'b1;
                  state_ff           <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

### src/stoq_checker.sv
// Port-level checks for sorted_timeout_queue_unit and the bind that attaches them.
// Depends on stoq_pkg and sorted_timeout_queue_unit.
`timescale 1ns / 1ps

module stoq_checker import stoq_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result item changed while stalled");

   // a reject is always the only, hence last, result of its item
   a_reject_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == STATUS_REJECTED) |-> rsp_data.last)
      else $error("reject result without last");

   // no new item while a tick still has results to give
   a_busy_mid_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last |-> !req_ready)
      else $error("request taken during expiry burst");

   // a tick always passes through the drain state to check the head
   a_tick_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_data.kind == KIND_TICK) |=> !req_ready)
      else $error("ready right after a tick");

endmodule

bind sorted_timeout_queue_unit stoq_checker u_stoq_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
